// ===== rtl/gbts_pkg.sv =====
package gbts_pkg;

  // Default text capacity in bytes
  localparam int unsigned CAPACITY_DEF = 4096;

  // Fixed field widths of the command and result channels
  localparam int unsigned POS_W  = 13;
  localparam int unsigned CMD_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 2;

  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 4'd0,
    CMD_BACKSPACE = 4'd1,
    CMD_DELETE    = 4'd2,
    CMD_LEFT      = 4'd3,
    CMD_RIGHT     = 4'd4,
    CMD_SET       = 4'd5,
    CMD_READ      = 4'd6,
    CMD_START     = 4'd7,
    CMD_END       = 4'd8
  } cmd_e;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_EDIT,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  text_length;
    logic [BYTE_W-1:0] char_at_cursor;
    logic [STAT_W-1:0] status;
    logic              dirty;
  } res_t;

endpackage

// ===== rtl/gap_buffer_text_store.sv =====
// Gap buffer text store.
//
// Command channel: drive req_i and raise start_i; the command is taken at a
// rising edge where start_i is high and busy_o is low. busy_o stays high
// until the result has been shown.
// Result channel: res_o is valid for exactly one cycle while done_o is high.
// The receiver cannot stall it and must take it in that cycle.
//
// done_o is high in S_RESP, which the command reaches through S_MOVE (only
// for insert, backspace and delete, and not for an insert into a full
// buffer), then S_EDIT and S_READ; the result transfers at the edge that
// ends it. Motion and read commands go straight to S_EDIT. In S_MOVE the
// gap travels to the cursor. A new command can be accepted in the cycle
// after done_o. The gap move copies one byte per cycle through the simple
// dual-port text memory (one read, one write per cycle, read data
// registered).
//
// Reset empties the buffer: gap covers all CAPACITY bytes, cursor at 0,
// dirty flag clear. Memory contents are not cleared; a byte read from a
// cell that holds no text is not passed on as char_at_cursor.
module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  state_e state_q, state_d;
  logic [PW-1:0] gs_q, gs_d, ge_q, ge_d, cur_q, cur_d;
  logic          mod_q, mod_d;
  logic          wpend_q, wpend_d;
  logic [AW-1:0] wdest_q, wdest_d;
  req_t          req_q;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [BYTE_W-1:0] rdata_q;

  logic [7:0]    text_mem [CAPACITY];

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [PW-1:0] len, gap_sz, phys;
  logic          accept, edit_cmd, full;

  assign gap_sz = ge_q - gs_q;
  assign len    = CAP_P - gap_sz;
  assign full   = (gs_q == ge_q);
  assign accept = start_i && (state_q == S_IDLE);

  // Map the cursor onto its memory cell
  always_comb begin
    phys = (cur_q < gs_q) ? cur_q : cur_q + gap_sz;
    if (phys >= CAP_P) begin
      phys = '0;
    end
  end

  // Commands that move the gap before editing
  always_comb begin
    case (cmd_e'(req_i.cmd))
      CMD_INSERT:    edit_cmd = !full;
      CMD_BACKSPACE: edit_cmd = 1'b1;
      CMD_DELETE:    edit_cmd = 1'b1;
      default:       edit_cmd = 1'b0;
    endcase
  end

  // Next state, datapath updates and memory port control
  always_comb begin
    state_d = state_q;
    gs_d    = gs_q;
    ge_d    = ge_q;
    cur_d   = cur_q;
    mod_d   = mod_q;
    stat_d  = stat_q;
    wdest_d = wdest_q;
    wpend_d = 1'b0;
    mem_re  = 1'b0;
    mem_ra  = AW'(phys);
    // Drain the write half of a gap move by default
    mem_we  = wpend_q;
    mem_wa  = wdest_q;
    mem_wd  = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = edit_cmd ? S_MOVE : S_EDIT;
        end
      end

      S_MOVE: begin
        if (cur_q < gs_q) begin
          // Shift one byte from before the gap to its end
          mem_re  = 1'b1;
          mem_ra  = AW'(gs_q - 1'b1);
          gs_d    = gs_q - 1'b1;
          ge_d    = ge_q - 1'b1;
          wdest_d = AW'(ge_q - 1'b1);
          wpend_d = 1'b1;
        end else if (cur_q > gs_q) begin
          // Shift one byte from after the gap to its start
          mem_re  = 1'b1;
          mem_ra  = AW'(ge_q);
          gs_d    = gs_q + 1'b1;
          ge_d    = ge_q + 1'b1;
          wdest_d = AW'(gs_q);
          wpend_d = 1'b1;
        end else begin
          state_d = S_EDIT;
        end
      end

      S_EDIT: begin
        stat_d  = STAT_OK;
        state_d = S_READ;
        case (cmd_e'(req_q.cmd))
          CMD_INSERT: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else begin
              mem_we = 1'b1;
              mem_wa = AW'(gs_q);
              mem_wd = (req_q.data_byte == BYTE_CR) ? BYTE_LF : req_q.data_byte;
              gs_d   = gs_q + 1'b1;
              cur_d  = gs_q + 1'b1;
              mod_d  = 1'b1;
            end
          end
          CMD_BACKSPACE: begin
            if (gs_q != '0) begin
              gs_d  = gs_q - 1'b1;
              cur_d = gs_q - 1'b1;
              mod_d = 1'b1;
            end else begin
              stat_d = STAT_NONE;
              cur_d  = gs_q;
            end
          end
          CMD_DELETE: begin
            cur_d = gs_q;
            if (ge_q < CAP_P) begin
              ge_d  = ge_q + 1'b1;
              mod_d = 1'b1;
            end else begin
              stat_d = STAT_NONE;
            end
          end
          CMD_LEFT: begin
            if (cur_q != '0) begin
              cur_d = cur_q - 1'b1;
            end else begin
              stat_d = STAT_NONE;
            end
          end
          CMD_RIGHT: begin
            if (cur_q < len) begin
              cur_d = cur_q + 1'b1;
            end else begin
              stat_d = STAT_NONE;
            end
          end
          CMD_SET: begin
            if (CW'(req_q.position) <= CW'(len)) begin
              cur_d = PW'(req_q.position);
            end else begin
              stat_d = STAT_NONE;
            end
          end
          CMD_READ: begin
          end
          CMD_START: begin
            cur_d = '0;
          end
          CMD_END: begin
            cur_d = len;
          end
          default: begin
            stat_d = STAT_NONE;
          end
        endcase
      end

      S_READ: begin
        // Fetch the byte under the cursor
        mem_re  = 1'b1;
        state_d = S_RESP;
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and gap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gs_q    <= '0;
      ge_q    <= CAP_P;
      cur_q   <= '0;
      mod_q   <= 1'b0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      ge_q    <= ge_d;
      cur_q   <= cur_d;
      mod_q   <= mod_d;
      wpend_q <= wpend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    stat_q  <= stat_d;
    wdest_q <= wdest_d;
  end

  // Text memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      text_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= text_mem[mem_ra];
    end
  end

  // Result outputs
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  always_comb begin
    res_o.cursor         = POS_W'(cur_q);
    res_o.text_length    = POS_W'(len);
    res_o.char_at_cursor = (cur_q < len) ? rdata_q : '0;
    res_o.status         = stat_q;
    res_o.dirty          = mod_q;
  end

  // Gap bounds stay ordered and inside the memory
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gs_q <= ge_q) && (ge_q <= CAP_P))
    else $error("gap bounds out of order");

  // Cursor never passes the end of the text
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len)
    else $error("cursor beyond text length");

  // A pending move write is drained before the edit step
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDIT) |-> !wpend_q)
    else $error("move write still pending at edit");

  // An accepted command leads into the move or edit step
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == S_MOVE) || (state_q == S_EDIT)))
    else $error("accepted command lost");

  // One result per command
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result repeated");

endmodule
